// ----- src/text_console_writer_top_assert.svh -----
// Assertion macros for the text console writer.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tcw assertion failed");
`define TCW_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tcw assertion failed");
`else
`define TCW_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define TCW_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ----- src/tcw_pkg.sv -----
// Shared types and constants of the text console writer.
// Used by tcw_ctrl, tcw_datapath and text_console_writer_top.
package tcw_pkg;

	localparam int CHAR_W    = 8;
	localparam int ROW_W     = 5;
	localparam int COL_W     = 7;
	localparam int COLOR_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

	localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

	typedef enum logic [2:0] {
		WOP_NONE,
		WOP_ZERO,
		WOP_CHAR,
		WOP_BS,
		WOP_COPY,
		WOP_BLANK
	} wop_t;

	typedef enum logic [1:0] {
		PTR_HOLD,
		PTR_INC,
		PTR_COPY,
		PTR_BLANK
	} ptr_op_t;

	typedef struct packed {
		logic    item_load;
		ptr_op_t ptr_op;
		wop_t    wop;
		logic    rd_cell;
		logic    rd_copy;
		logic    scroll_set;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic is_newline;
		logic is_backspace;
		logic line_full;
		logic ptr_last;
	} status_t;

endpackage

// ----- src/tcw_datapath.sv -----
// Datapath of the text console writer: screen memory, cursor, colour registers,
// scroll pointer, write stage and result register. Depends on tcw_pkg.
module tcw_datapath import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 kind,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [ROW_W-1:0]     read_row,
	input  logic [COL_W-1:0]     read_col,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	input  cmd_t                 cmd,
	output status_t              status,
	output logic [COL_W-1:0]     cursor_col,
	output logic                 scrolled,
	output logic [CHAR_W-1:0]    cell_char,
	output logic [CHAR_W-1:0]    cell_color
);

	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(COLUMNS);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
	localparam logic [AW-1:0] COPY_START = AW'(2 * COLUMNS);
	localparam logic [AW-1:0] BOTTOM     = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);
	localparam logic [CW-1:0] LAST_COL   = CW'(COLUMNS - 1);

	logic [15:0]          mem [DEPTH];
	logic [15:0]          rd_q;
	logic [COLOR_W-1:0]   fg_q, bg_q;
	logic                 kind_q;
	logic [CHAR_W-1:0]    char_q;
	logic [ROW_W-1:0]     row_q;
	logic [COL_W-1:0]     col_q;
	logic [CW-1:0]        cur_q;
	logic [AW-1:0]        ptr_q;
	logic                 scroll_q;
	logic                 wr_en_s1, wr_copy_s1;
	logic [AW-1:0]        wr_addr_s1;
	logic [15:0]          wr_data_s1;
	logic [COL_W-1:0]     cursor_col_q;
	logic                 scrolled_q;
	logic [CHAR_W-1:0]    cell_char_q, cell_color_q;

	logic [7:0]           attr;
	logic [CW-1:0]        cur_back;
	logic                 in_range;
	logic [AW-1:0]        cell_addr, rd_addr;
	logic                 wr_en_d, wr_copy_d;
	logic [AW-1:0]        wr_addr_d;
	logic [15:0]          wr_data_d;

	always_comb begin
		attr      = {bg_q, fg_q};
		cur_back  = (cur_q == '0) ? '0 : cur_q - CW'(1);
		in_range  = (int'(row_q) < ROWS) && (int'(col_q) < COLUMNS);
		cell_addr = AW'(int'(row_q) * COLUMNS + int'(col_q));
		rd_addr   = cmd.rd_cell ? cell_addr : ptr_q;

		status.is_read      = kind_q;
		status.is_newline   = (char_q == CH_NEWLINE);
		status.is_backspace = (char_q == CH_BACKSPACE);
		status.line_full    = (cur_q == LAST_COL);
		status.ptr_last     = (ptr_q == LAST_ADDR);
	end

	// Every memory write passes through one register stage.
	always_comb begin
		wr_en_d   = 1'b1;
		wr_copy_d = 1'b0;
		wr_addr_d = ptr_q;
		wr_data_d = '0;
		unique case (cmd.wop)
			WOP_NONE: begin
				wr_en_d = 1'b0;
			end
			WOP_ZERO: begin
				wr_data_d = '0;
			end
			WOP_CHAR: begin
				wr_addr_d = BOTTOM + AW'(cur_q);
				wr_data_d = {attr, char_q};
			end
			WOP_BS: begin
				wr_addr_d = BOTTOM + AW'(cur_back);
				wr_data_d = {attr, CH_SPACE};
			end
			WOP_COPY: begin
				wr_addr_d = ptr_q - ROW_STEP;
				wr_copy_d = 1'b1;
			end
			WOP_BLANK: begin
				wr_data_d = {attr, CH_SPACE};
			end
			default: begin
				wr_en_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q     <= FG_RESET;
			bg_q     <= BG_RESET;
			cur_q    <= '0;
			ptr_q    <= '0;
			scroll_q <= 1'b0;
			wr_en_s1 <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_FG) begin
				fg_q <= cfg_data;
			end
			if (cfg_we && cfg_index == REG_BG) begin
				bg_q <= cfg_data;
			end

			if (cmd.scroll_set) begin
				cur_q <= '0;
			end else if (cmd.wop == WOP_CHAR) begin
				cur_q <= cur_q + CW'(1);
			end else if (cmd.wop == WOP_BS) begin
				cur_q <= cur_back;
			end

			unique case (cmd.ptr_op)
				PTR_HOLD:  ptr_q <= ptr_q;
				PTR_INC:   ptr_q <= ptr_q + AW'(1);
				PTR_COPY:  ptr_q <= COPY_START;
				PTR_BLANK: ptr_q <= BOTTOM;
				default:   ptr_q <= ptr_q;
			endcase

			if (cmd.item_load) begin
				scroll_q <= 1'b0;
			end else if (cmd.scroll_set) begin
				scroll_q <= 1'b1;
			end

			wr_en_s1 <= wr_en_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			kind_q <= kind;
			char_q <= char_code;
			row_q  <= read_row;
			col_q  <= read_col;
		end
		wr_copy_s1 <= wr_copy_d;
		wr_addr_s1 <= wr_addr_d;
		wr_data_s1 <= wr_data_d;
		if (cmd.emit) begin
			cursor_col_q <= COL_W'(cur_q);
			scrolled_q   <= scroll_q;
			cell_char_q  <= (kind_q && in_range) ? rd_q[7:0] : '0;
			cell_color_q <= (kind_q && in_range) ? rd_q[15:8] : '0;
		end
	end

	// Copy data is the word read from one row below in the previous cycle.
	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			mem[wr_addr_s1] <= wr_copy_s1 ? rd_q : wr_data_s1;
		end
		if (cmd.rd_cell || cmd.rd_copy) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign cursor_col = cursor_col_q;
	assign scrolled   = scrolled_q;
	assign cell_char  = cell_char_q;
	assign cell_color = cell_color_q;

endmodule

// ----- src/tcw_ctrl.sv -----
// Controller of the text console writer: sequences clearing, item handling,
// scroll copy and blanking, and the result handshake. Depends on tcw_pkg.
`include "text_console_writer_top_assert.svh"

module tcw_ctrl import tcw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_EXEC  = 6'b000100,
		S_COPY  = 6'b001000,
		S_BLANK = 6'b010000,
		S_EMIT  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		cmd.item_load  = 1'b0;
		cmd.ptr_op     = PTR_HOLD;
		cmd.wop        = WOP_NONE;
		cmd.rd_cell    = 1'b0;
		cmd.rd_copy    = 1'b0;
		cmd.scroll_set = 1'b0;
		cmd.emit       = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.wop    = WOP_ZERO;
				cmd.ptr_op = PTR_INC;
				if (status.ptr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.item_load = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				priority if (status.is_read) begin
					cmd.rd_cell = 1'b1;
					state_d     = S_EMIT;
				end else if (status.is_newline) begin
					cmd.scroll_set = 1'b1;
					cmd.ptr_op     = PTR_COPY;
					state_d        = S_COPY;
				end else if (status.is_backspace) begin
					cmd.wop = WOP_BS;
					state_d = S_EMIT;
				end else begin
					cmd.wop = WOP_CHAR;
					if (status.line_full) begin
						cmd.scroll_set = 1'b1;
						cmd.ptr_op     = PTR_COPY;
						state_d        = S_COPY;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_COPY: begin
				cmd.wop     = WOP_COPY;
				cmd.rd_copy = 1'b1;
				if (status.ptr_last) begin
					cmd.ptr_op = PTR_BLANK;
					state_d    = S_BLANK;
				end else begin
					cmd.ptr_op = PTR_INC;
				end
			end
			S_BLANK: begin
				cmd.wop    = WOP_BLANK;
				cmd.ptr_op = PTR_INC;
				if (status.ptr_last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				// hold the result until the output register is free
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`TCW_ASSERT_IMP(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || out_ready)
	`TCW_ASSERT_IMP(a_clear_blocks, clk, arst_n, state_q == S_CLEAR, !in_ready)
	`TCW_ASSERT_NXT(a_copy_to_blank, clk, arst_n, (state_q == S_COPY) && status.ptr_last, state_q == S_BLANK)

endmodule

// ----- src/text_console_writer_top.sv -----
// Text console writer: a read, a plain character or a backspace goes from the execute state
// to the emit state, which waits for a free output register, registers the result and returns
// to idle for the next item. A newline or a full line first copies the rows up, one cycle per
// cell through the screen memory, then blanks the bottom row, one cycle per cell. After reset
// the screen memory is cleared cell by cell before the first item is taken; configuration
// writes are taken at any time. Depends on tcw_pkg, tcw_ctrl, tcw_datapath.
module text_console_writer_top import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [CHAR_W-1:0]    char_code,
	input  logic [ROW_W-1:0]     read_row,
	input  logic [COL_W-1:0]     read_col,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [COL_W-1:0]     cursor_col,
	output logic                 scrolled,
	output logic [CHAR_W-1:0]    cell_char,
	output logic [CHAR_W-1:0]    cell_color,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.kind       (kind),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status),
		.cursor_col (cursor_col),
		.scrolled   (scrolled),
		.cell_char  (cell_char),
		.cell_color (cell_color)
	);

endmodule
